@@ hw/rtl/lpfb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfb_pkg
// Shared field widths, codes and the result beat type of the frame buffer.
// ----------------------------------------------------------------------------
package lpfb_pkg;

	localparam int OP_W    = 1;
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 7;
	localparam int KIND_W  = 2;
	localparam int ERR_W   = 3;
	localparam int HCNT_W  = 3;
	localparam int HDR_W   = 24;
	localparam int LEN_W   = 32;

	// header bytes held before the fourth one completes the length
	localparam logic [HCNT_W-1:0] HDR_LAST = 3'd3;
	localparam logic [LEN_W-1:0]  HDR_LEN  = 32'd4;

	typedef enum logic [OP_W-1:0] {
		OP_LINK = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		RK_STATUS = 2'd0,
		RK_DATA   = 2'd1,
		RK_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE        = 3'd0,
		ERR_NO_FRAME    = 3'd1,
		ERR_PAST_FRAME  = 3'd2,
		ERR_UNCONSUMED  = 3'd3,
		ERR_SHORT_LEN   = 3'd4,
		ERR_TOO_LONG    = 3'd5
	} err_t;

	typedef enum logic [3:0] {
		PH_HUNT  = 4'b0001,
		PH_FILL  = 4'b0010,
		PH_READY = 4'b0100,
		PH_SKIP  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic              frame_ready;
		logic              last;
		err_t              err;
	} rslt_t;

endpackage

@@ hw/rtl/length_prefixed_frame_buffer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_buffer_unit
// Deframer for a link carrying 4-byte big-endian length-prefixed frames;
// holds one frame payload in a store and serves consumer read requests.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   operation, link_byte, read_count
//  out      out_valid / out_ready result_kind, data_out, frame_ready,
//                                 last_of_run, error_code
//
//  A link beat, a rejected read or an empty read gives one result in the cycle after it is
//  taken; a link beat every cycle is sustained while the output drains.
//  A read of n bytes streams n data beats, one per cycle while the output
//  drains, from the store's single read port through the read stage.
//  The next item is taken once the last read byte has reached the output.
//  Reset clears all control state; the store holds no reset and is only
//  read where the current frame has written it.
//  An output stall holds the output register and the read stage in place.
// ----------------------------------------------------------------------------
module length_prefixed_frame_buffer_unit #(
	parameter int BUFFER_DEPTH = 4096,
	parameter int MAX_READ = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lpfb_pkg::OP_W-1:0]     operation,
	input  logic [lpfb_pkg::BYTE_W-1:0]   link_byte,
	input  logic [lpfb_pkg::COUNT_W-1:0]  read_count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lpfb_pkg::KIND_W-1:0]   result_kind,
	output logic [lpfb_pkg::BYTE_W-1:0]   data_out,
	output logic                          frame_ready,
	output logic                          last_of_run,
	output logic [lpfb_pkg::ERR_W-1:0]    error_code
);

	import lpfb_pkg::*;

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int CW = $clog2(MAX_READ + 1);

	logic              in_fire;
	rslt_t             single;
	logic              strm_start;
	logic [AW-1:0]     strm_addr;
	logic [CW-1:0]     strm_count;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [BYTE_W-1:0] rd_data;
	rslt_t             out_beat;

	assign in_fire = in_valid && in_ready;

	lpfb_ctl #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.MAX_READ(MAX_READ)
	) u_ctl (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_fire),
		.operation(operation),
		.link_byte(link_byte),
		.read_count(read_count),
		.single(single),
		.strm_start(strm_start),
		.strm_addr(strm_addr),
		.strm_count(strm_count),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	lpfb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BUFFER_DEPTH)
	) u_store (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	lpfb_stream #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.MAX_READ(MAX_READ)
	) u_stream (
		.clk(clk),
		.arst_n(arst_n),
		.single(single),
		.strm_start(strm_start),
		.strm_addr(strm_addr),
		.strm_count(strm_count),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.accept_ok(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_beat(out_beat)
	);

	assign result_kind = out_beat.kind;
	assign data_out    = out_beat.data;
	assign frame_ready = out_beat.frame_ready;
	assign last_of_run = out_beat.last;
	assign error_code  = out_beat.err;

endmodule

@@ hw/rtl/lpfb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/lpfb_ctl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfb_ctl
// Frame state: header hunting, payload fill, oversize skip and read checks.
// Produces one result per beat, or a stream command for a valid non-empty read.
// ----------------------------------------------------------------------------
module lpfb_ctl #(
	parameter int BUFFER_DEPTH = 4096,
	parameter int MAX_READ = 64,
	localparam int AW = $clog2(BUFFER_DEPTH),
	localparam int CW = $clog2(MAX_READ + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_fire,
	input  logic [lpfb_pkg::OP_W-1:0]     operation,
	input  logic [lpfb_pkg::BYTE_W-1:0]   link_byte,
	input  logic [lpfb_pkg::COUNT_W-1:0]  read_count,
	output lpfb_pkg::rslt_t               single,
	output logic                          strm_start,
	output logic [AW-1:0]                 strm_addr,
	output logic [CW-1:0]                 strm_count,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic [lpfb_pkg::BYTE_W-1:0]   wr_data
);

	import lpfb_pkg::*;

	localparam int LW = $clog2(BUFFER_DEPTH + 1);
	localparam int SW = ((LW > CW) ? LW : CW) + 1;

	phase_t            phase_q, phase_d;
	logic [HDR_W-1:0]  shift_q, shift_d;
	logic [HCNT_W-1:0] hcnt_q, hcnt_d;
	logic [LW-1:0]     plen_q, plen_d;
	logic [LW-1:0]     fill_q, fill_d;
	logic [LW-1:0]     rpos_q, rpos_d;
	logic [LEN_W-1:0]  skip_q, skip_d;

	logic [CW-1:0]     n;
	logic [LEN_W-1:0]  total;
	logic [LEN_W-1:0]  plen_full;
	logic [SW-1:0]     rd_end;
	logic [LEN_W-1:0]  skip_dec;

	always_comb begin
		phase_d    = phase_q;
		shift_d    = shift_q;
		hcnt_d     = hcnt_q;
		plen_d     = plen_q;
		fill_d     = fill_q;
		rpos_d     = rpos_q;
		skip_d     = skip_q;
		single     = '0;
		strm_start = 1'b0;
		wr_en      = 1'b0;

		n         = (read_count > COUNT_W'(MAX_READ)) ? CW'(MAX_READ) : CW'(read_count);
		total     = {shift_q, link_byte};
		plen_full = total - HDR_LEN;
		rd_end    = SW'(rpos_q) + SW'(n);
		skip_dec  = (skip_q != '0) ? skip_q - LEN_W'(1) : '0;

		if (in_fire) begin
			single.valid = 1'b1;
			single.last  = 1'b1;
			single.kind  = RK_STATUS;
			single.err   = ERR_NONE;
			if (operation == OP_LINK) begin
				case (phase_q)
					PH_READY: begin
						if (rpos_q != plen_q) begin
							single.kind = RK_ERROR;
							single.err  = ERR_UNCONSUMED;
						end else begin
							// frame released, this beat opens the next header
							phase_d = PH_HUNT;
							shift_d = HDR_W'(link_byte);
							hcnt_d  = HCNT_W'(1);
							fill_d  = '0;
							rpos_d  = '0;
							plen_d  = '0;
						end
					end
					PH_HUNT: begin
						if (hcnt_q != HDR_LAST) begin
							shift_d = {shift_q[HDR_W-BYTE_W-1:0], link_byte};
							hcnt_d  = hcnt_q + HCNT_W'(1);
						end else begin
							shift_d = '0;
							hcnt_d  = '0;
							fill_d  = '0;
							rpos_d  = '0;
							if (total < HDR_LEN) begin
								plen_d      = '0;
								single.kind = RK_ERROR;
								single.err  = ERR_SHORT_LEN;
							end else if (plen_full > LEN_W'(BUFFER_DEPTH)) begin
								skip_d      = plen_full;
								plen_d      = '0;
								phase_d     = PH_SKIP;
								single.kind = RK_ERROR;
								single.err  = ERR_TOO_LONG;
							end else begin
								plen_d  = LW'(plen_full);
								phase_d = (plen_full == '0) ? PH_READY : PH_FILL;
							end
						end
					end
					PH_FILL: begin
						wr_en  = 1'b1;
						fill_d = fill_q + LW'(1);
						if (fill_d >= plen_q) begin
							phase_d = PH_READY;
						end
					end
					PH_SKIP: begin
						skip_d = skip_dec;
						if (skip_dec == '0) begin
							phase_d = PH_HUNT;
						end
					end
					default: begin
						phase_d = PH_HUNT;
					end
				endcase
			end else begin
				if (phase_q != PH_READY) begin
					single.kind = RK_ERROR;
					single.err  = ERR_NO_FRAME;
				end else if (rd_end > SW'(plen_q)) begin
					single.kind = RK_ERROR;
					single.err  = ERR_PAST_FRAME;
				end else if (n != '0) begin
					single.valid = 1'b0;
					strm_start   = 1'b1;
					rpos_d       = LW'(rd_end);
				end
			end
			single.frame_ready = (phase_d == PH_READY);
		end
	end

	assign strm_addr  = rpos_q[AW-1:0];
	assign strm_count = n;
	assign wr_addr    = fill_q[AW-1:0];
	assign wr_data    = link_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			shift_q <= '0;
			hcnt_q  <= '0;
			plen_q  <= '0;
			fill_q  <= '0;
			rpos_q  <= '0;
			skip_q  <= '0;
		end else begin
			phase_q <= phase_d;
			shift_q <= shift_d;
			hcnt_q  <= hcnt_d;
			plen_q  <= plen_d;
			fill_q  <= fill_d;
			rpos_q  <= rpos_d;
			skip_q  <= skip_d;
		end
	end

	// store is written only while a frame is filling, never past its length
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (phase_q == PH_FILL) && (fill_q < plen_q))
		else $error("lpfb_ctl: store write outside payload fill");

	// consumed bytes never run ahead of the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		rpos_q <= plen_q)
		else $error("lpfb_ctl: read position past frame length");

endmodule

@@ hw/rtl/lpfb_stream.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfb_stream
// Read sequencer and output register: issues store reads one per cycle while
// the output drains, and holds the returned byte in a stage while it stalls.
// ----------------------------------------------------------------------------
module lpfb_stream #(
	parameter int BUFFER_DEPTH = 4096,
	parameter int MAX_READ = 64,
	localparam int AW = $clog2(BUFFER_DEPTH),
	localparam int CW = $clog2(MAX_READ + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lpfb_pkg::rslt_t               single,
	input  logic                          strm_start,
	input  logic [AW-1:0]                 strm_addr,
	input  logic [CW-1:0]                 strm_count,
	output logic                          rd_en,
	output logic [AW-1:0]                 rd_addr,
	input  logic [lpfb_pkg::BYTE_W-1:0]   rd_data,
	output logic                          accept_ok,
	output logic                          out_valid,
	input  logic                          out_ready,
	output lpfb_pkg::rslt_t               out_beat
);

	import lpfb_pkg::*;

	logic [CW-1:0] rem_q;
	logic [AW-1:0] addr_q;
	logic          valid_s1;
	logic          last_s1;
	logic          out_valid_q;
	rslt_t         out_q;

	logic          out_free;
	logic          s1_move;

	assign out_free  = !out_valid_q || out_ready;
	assign s1_move   = valid_s1 && out_free;
	assign rd_en     = (rem_q != '0) && (!valid_s1 || s1_move);
	assign rd_addr   = addr_q;
	assign accept_ok = (rem_q == '0) && !valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			addr_q      <= '0;
			valid_s1    <= 1'b0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (strm_start) begin
				rem_q  <= strm_count;
				addr_q <= strm_addr;
			end else if (rd_en) begin
				rem_q  <= rem_q - CW'(1);
				addr_q <= addr_q + AW'(1);
			end

			if (rd_en) begin
				valid_s1 <= 1'b1;
				last_s1  <= (rem_q == CW'(1));
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end

			if (single.valid || s1_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (single.valid) begin
			out_q <= single;
		end else if (s1_move) begin
			out_q.valid       <= 1'b1;
			out_q.kind        <= RK_DATA;
			out_q.data        <= rd_data;
			out_q.frame_ready <= 1'b1;
			out_q.last        <= last_s1;
			out_q.err         <= ERR_NONE;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

	// a new item only lands on an empty sequencer and a free output
	assert property (@(posedge clk) disable iff (!arst_n)
		(single.valid || strm_start) |-> (rem_q == '0) && !valid_s1 && out_free)
		else $error("lpfb_stream: item taken while output path busy");

	// a stalled read byte is neither lost nor overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> valid_s1 && $stable(rd_data) && $stable(last_s1))
		else $error("lpfb_stream: stalled read stage changed");

	// the final byte of a run carries the end mark
	assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && (rem_q == CW'(1))) |=> last_s1 && (rem_q == '0))
		else $error("lpfb_stream: end of run not marked");

endmodule

@@ tb/deframe_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframe_checker
// Watches both channels of the frame buffer. It keeps its own copy of the
// header, fill and read state to work out the result beats of every accepted
// input beat, and compares each output beat field by field with the oldest one.
// ----------------------------------------------------------------------------
module deframe_checker #(
	parameter int BUFFER_DEPTH = 4096,
	parameter int MAX_READ = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [lpfb_pkg::OP_W-1:0]     operation,
	input  logic [lpfb_pkg::BYTE_W-1:0]   link_byte,
	input  logic [lpfb_pkg::COUNT_W-1:0]  read_count,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [lpfb_pkg::KIND_W-1:0]   result_kind,
	input  logic [lpfb_pkg::BYTE_W-1:0]   data_out,
	input  logic                          frame_ready,
	input  logic                          last_of_run,
	input  logic [lpfb_pkg::ERR_W-1:0]    error_code,
	output int                            fail_count,
	output int                            pending
);

	typedef struct {
		lpfb_pkg::kind_t           kind;
		logic [lpfb_pkg::BYTE_W-1:0] data;
		logic                      ready;
		logic                      last;
		lpfb_pkg::err_t            err;
	} beat_t;

	beat_t expected_beats[$];

	logic [lpfb_pkg::BYTE_W-1:0] frame_mem [BUFFER_DEPTH];
	logic [lpfb_pkg::HDR_W-1:0]  hdr_bytes;
	logic [lpfb_pkg::HCNT_W-1:0] hdr_seen;
	logic [lpfb_pkg::LEN_W-1:0]  frame_len;
	logic [lpfb_pkg::LEN_W-1:0]  fill_pos;
	logic [lpfb_pkg::LEN_W-1:0]  read_pos;
	logic [lpfb_pkg::LEN_W-1:0]  skip_left;
	lpfb_pkg::phase_t            stage;
	int                          mismatch_count;

	// frame_ready reflects the phase after this beat's update
	function automatic void push_result(lpfb_pkg::kind_t k, logic [7:0] d, logic l,
			lpfb_pkg::err_t e);
		beat_t r;
		r.kind  = k;
		r.data  = d;
		r.ready = (stage == lpfb_pkg::PH_READY);
		r.last  = l;
		r.err   = e;
		expected_beats.push_back(r);
	endfunction

	function automatic void absorb_link_byte(logic [7:0] b);
		logic [lpfb_pkg::LEN_W-1:0] total;
		if (stage == lpfb_pkg::PH_READY) begin
			if (read_pos != frame_len) begin
				push_result(lpfb_pkg::RK_ERROR, 8'h00, 1'b1, lpfb_pkg::ERR_UNCONSUMED);
				return;
			end
			// frame fully read: release it, this byte opens the next header
			stage     = lpfb_pkg::PH_HUNT;
			hdr_bytes = '0;
			hdr_seen  = '0;
			fill_pos  = '0;
			read_pos  = '0;
			frame_len = '0;
		end
		if (stage == lpfb_pkg::PH_HUNT) begin
			if (hdr_seen < lpfb_pkg::HDR_LAST) begin
				hdr_bytes = {hdr_bytes[15:0], b};
				hdr_seen  = hdr_seen + 1'b1;
				push_result(lpfb_pkg::RK_STATUS, 8'h00, 1'b1, lpfb_pkg::ERR_NONE);
				return;
			end
			total     = {hdr_bytes, b};
			hdr_bytes = '0;
			hdr_seen  = '0;
			fill_pos  = '0;
			read_pos  = '0;
			if (total < lpfb_pkg::HDR_LEN) begin
				frame_len = '0;
				push_result(lpfb_pkg::RK_ERROR, 8'h00, 1'b1, lpfb_pkg::ERR_SHORT_LEN);
				return;
			end
			frame_len = total - lpfb_pkg::HDR_LEN;
			if (frame_len > BUFFER_DEPTH) begin
				skip_left = frame_len;
				frame_len = '0;
				stage     = lpfb_pkg::PH_SKIP;
				push_result(lpfb_pkg::RK_ERROR, 8'h00, 1'b1, lpfb_pkg::ERR_TOO_LONG);
				return;
			end
			if (frame_len == 0)
				stage = lpfb_pkg::PH_READY;
			else
				stage = lpfb_pkg::PH_FILL;
			push_result(lpfb_pkg::RK_STATUS, 8'h00, 1'b1, lpfb_pkg::ERR_NONE);
			return;
		end
		if (stage == lpfb_pkg::PH_FILL) begin
			if (fill_pos < BUFFER_DEPTH)
				frame_mem[fill_pos] = b;
			fill_pos = fill_pos + 1;
			if (fill_pos >= frame_len)
				stage = lpfb_pkg::PH_READY;
			push_result(lpfb_pkg::RK_STATUS, 8'h00, 1'b1, lpfb_pkg::ERR_NONE);
			return;
		end
		// dropping the body of an oversized frame
		if (skip_left > 0)
			skip_left = skip_left - 1;
		if (skip_left == 0)
			stage = lpfb_pkg::PH_HUNT;
		push_result(lpfb_pkg::RK_STATUS, 8'h00, 1'b1, lpfb_pkg::ERR_NONE);
	endfunction

	function automatic void serve_read(logic [6:0] count);
		logic [lpfb_pkg::LEN_W-1:0] n;
		logic [lpfb_pkg::LEN_W-1:0] p;
		logic [7:0]                 d;
		int                         i;
		n = lpfb_pkg::LEN_W'(count);
		if (n > MAX_READ)
			n = MAX_READ;
		if (stage != lpfb_pkg::PH_READY) begin
			push_result(lpfb_pkg::RK_ERROR, 8'h00, 1'b1, lpfb_pkg::ERR_NO_FRAME);
		end else if (n > frame_len || read_pos > frame_len - n) begin
			push_result(lpfb_pkg::RK_ERROR, 8'h00, 1'b1, lpfb_pkg::ERR_PAST_FRAME);
		end else if (n == 0) begin
			push_result(lpfb_pkg::RK_STATUS, 8'h00, 1'b1, lpfb_pkg::ERR_NONE);
		end else begin
			for (i = 0; i < n; i++) begin
				p = read_pos + i;
				d = (p < BUFFER_DEPTH) ? frame_mem[p] : 8'h00;
				push_result(lpfb_pkg::RK_DATA, d, (i + 1 == n), lpfb_pkg::ERR_NONE);
			end
			read_pos = read_pos + n;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		beat_t want;
		if (!arst_n) begin
			hdr_bytes      = '0;
			hdr_seen       = '0;
			frame_len      = '0;
			fill_pos       = '0;
			read_pos       = '0;
			skip_left      = '0;
			stage          = lpfb_pkg::PH_HUNT;
			mismatch_count = 0;
			expected_beats.delete();
		end else begin
			if (in_valid && in_ready) begin
				if (operation == lpfb_pkg::OP_LINK)
					absorb_link_byte(link_byte);
				else
					serve_read(read_count);
			end
			if (out_valid === 1'b1 && out_ready) begin
				if (expected_beats.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: unexpected result beat kind %0d data %02h err %0d",
							$time, result_kind, data_out, error_code);
					mismatch_count++;
				end else begin
					want = expected_beats.pop_front();
					if (result_kind !== want.kind || data_out !== want.data ||
							frame_ready !== want.ready || last_of_run !== want.last ||
							error_code !== want.err) begin
						if (mismatch_count < 10)
							$display({"%0t: result mismatch: exp kind %0d data %02h rdy %0b ",
								"last %0b err %0d / got kind %0d data %02h rdy %0b last %0b ",
								"err %0d"}, $time, want.kind, want.data, want.ready, want.last,
								want.err, result_kind, data_out, frame_ready, last_of_run,
								error_code);
						mismatch_count++;
					end
				end
			end
		end
		fail_count <= mismatch_count;
		pending    <= expected_beats.size();
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives link bytes and read requests into the frame buffer: a short directed
// pass over the error cases, framed traffic with random payloads and noise
// under four idling mixes with one long output hold-off, then an oversized frame.
// ----------------------------------------------------------------------------
module testbench;
	import lpfb_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [OP_W-1:0]     operation;
	logic [BYTE_W-1:0]   link_byte;
	logic [COUNT_W-1:0]  read_count;
	logic                out_valid;
	logic                out_ready;
	logic [KIND_W-1:0]   result_kind;
	logic [BYTE_W-1:0]   data_out;
	logic                frame_ready;
	logic                last_of_run;
	logic [ERR_W-1:0]    error_code;
	int                  fail_count;
	int                  pending;

	int idle_pct;
	int stall_pct;
	int hold_reqs;
	int items_taken;

	length_prefixed_frame_buffer_unit u_top (.*);

	deframe_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// output side: random stalls, plus a long hold-off when requested
	initial begin
		int holds_done;
		int k;
		holds_done = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_reqs != holds_done) begin
				holds_done++;
				out_ready <= 1'b0;
				for (k = 0; k < 300; k++)
					@(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic offer_item(op_t op, logic [7:0] b, logic [6:0] n);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		link_byte  <= b;
		read_count <= n;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_taken++;
	endtask

	task automatic link_item(logic [7:0] b);
		offer_item(OP_LINK, b, 7'($urandom_range(127)));
	endtask

	task automatic read_item(logic [6:0] n);
		offer_item(OP_READ, 8'($urandom_range(255)), n);
	endtask

	task automatic send_header(logic [31:0] total);
		link_item(total[31:24]);
		link_item(total[23:16]);
		link_item(total[15:8]);
		link_item(total[7:0]);
	endtask

	// whole frame: header, payload, then reads until fully consumed
	task automatic run_frame(int len, bit noisy);
		int left;
		int n;
		int k;
		send_header(len + 4);
		for (k = 0; k < len; k++) begin
			if (noisy && $urandom_range(15) == 0)
				read_item(7'($urandom_range(1, 127)));
			link_item(8'($urandom_range(255)));
		end
		if (len == 0)
			read_item(($urandom_range(1) == 0) ? 7'd0 : 7'($urandom_range(1, 127)));
		left = len;
		while (left > 0) begin
			if (noisy) begin
				case ($urandom_range(7))
					0: link_item(8'($urandom_range(255)));
					1: read_item(7'd0);
					2: if (left < 64)
						read_item(7'($urandom_range(left + 1, 127)));
					3: if (left >= 64) begin
						// clamped to the read limit
						read_item(7'($urandom_range(65, 127)));
						left -= 64;
					end
					default: ;
				endcase
			end
			if (left > 0) begin
				n = $urandom_range(1, (left < 64) ? left : 64);
				read_item(7'(n));
				left -= n;
			end
		end
	endtask

	task automatic random_traffic(int goal);
		int len;
		goal += items_taken;
		while (items_taken < goal) begin
			case ($urandom_range(9))
				0: begin
					send_header($urandom_range(3));
					read_item(7'($urandom_range(1, 127)));
				end
				1: run_frame($urandom_range(64, 130), 1'($urandom_range(1)));
				default: begin
					len = $urandom_range(0, 40);
					run_frame(len, ($urandom_range(2) == 0));
				end
			endcase
		end
	endtask

	initial begin
		int k;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		operation   <= OP_LINK;
		link_byte   <= '0;
		read_count  <= '0;
		idle_pct    = 0;
		stall_pct   <= 0;
		hold_reqs   <= 0;
		items_taken = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: no frame, short length, empty frame, clamp, unconsumed byte
		read_item(7'd1);
		send_header(32'd2);
		send_header(32'd4);
		read_item(7'd0);
		read_item(7'd1);
		send_header(32'd7);
		link_item(8'hFF);
		link_item(8'h00);
		link_item(8'hA5);
		read_item(7'd127);
		read_item(7'd2);
		link_item(8'h5A);
		read_item(7'd1);

		// no idling; long output hold while a frame streams in
		hold_reqs <= hold_reqs + 1;
		run_frame(24, 1'b0);
		random_traffic(40);

		idle_pct = 60;
		random_traffic(40);

		idle_pct = 0;
		stall_pct <= 60;
		random_traffic(40);

		idle_pct = 20;
		stall_pct <= 20;
		random_traffic(40);

		// oversized frame: flagged, then the first body bytes are skipped
		send_header(32'd4101);
		for (k = 0; k < 8; k++)
			link_item(8'($urandom_range(255)));
		read_item(7'd1);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
